/* design/mphc_pkg.sv */
// ----------------------------------------------------------------------------
// mphc_pkg
// Shared types and codes for the meter poll health checker.
// ----------------------------------------------------------------------------
package mphc_pkg;

	localparam int unsigned WORD_W = 24;
	localparam logic [WORD_W-1:0] WORD_ONES = 24'hFF_FFFF;
	localparam logic [3:0] LAST_SLOT = 4'd13;

	// register addresses (byte address bits [3:2])
	localparam logic [1:0] REG_RESET_STATUS_MASK = 2'd0;
	localparam logic [1:0] REG_INTERVAL_SAMPLES = 2'd1;
	localparam logic [1:0] REG_INTERVAL_TRIES_LIMIT = 2'd2;
	localparam logic [1:0] REG_CLEAR_TRIES_LIMIT = 2'd3;

	// register reset values
	localparam logic [WORD_W-1:0] RST_RESET_STATUS_MASK = 24'h80_0000;
	localparam logic [WORD_W-1:0] RST_INTERVAL_SAMPLES = 24'd331;
	localparam logic [3:0] RST_INTERVAL_TRIES_LIMIT = 4'd2;
	localparam logic [3:0] RST_CLEAR_TRIES_LIMIT = 4'd3;

	// input kind
	localparam logic MODE_BUS_FAIL = 1'b0;
	localparam logic MODE_WORD = 1'b1;

	// error codes
	localparam logic [3:0] ERR_NONE = 4'd0;
	localparam logic [3:0] ERR_BUSY = 4'd1;
	localparam logic [3:0] ERR_TX = 4'd2;
	localparam logic [3:0] ERR_RX = 4'd3;
	localparam logic [3:0] ERR_SPI = 4'd4;
	localparam logic [3:0] ERR_ALL_ZERO = 4'd5;
	localparam logic [3:0] ERR_ALL_ONES = 4'd6;
	localparam logic [3:0] ERR_NO_LINK = 4'd7;
	localparam logic [3:0] ERR_STALE = 4'd8;

	// bus error codes
	localparam logic [1:0] BERR_BUSY = 2'd0;

	// housekeeping actions
	localparam logic [1:0] FIX_NONE = 2'd0;
	localparam logic [1:0] FIX_INTERVAL = 2'd1;
	localparam logic [1:0] FIX_CLEAR = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] reset_status_mask;
		logic [WORD_W-1:0] interval_samples;
		logic [3:0] interval_tries_limit;
		logic [3:0] clear_tries_limit;
	} mphc_cfg_t;

	typedef struct packed {
		logic mode;
		logic [1:0] bus_error;
		logic [3:0] word_index;
		logic [WORD_W-1:0] word_value;
	} mphc_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] fix_data;
		logic [1:0] fix_action;
		logic [3:0] error_code;
		logic bus_busy;
		logic meter_alive;
		logic link_good;
		logic poll_ok;
	} mphc_result_t;

endpackage

/* design/mphc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mphc_cfg_regs
// APB register file holding the checker's configuration.
// ----------------------------------------------------------------------------
module mphc_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output mphc_pkg::mphc_cfg_t cfg
);
	import mphc_pkg::*;

	mphc_cfg_t cfg_q;
	logic wr_en;
	logic [1:0] reg_sel;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_sel = paddr[3:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_status_mask <= RST_RESET_STATUS_MASK;
			cfg_q.interval_samples <= RST_INTERVAL_SAMPLES;
			cfg_q.interval_tries_limit <= RST_INTERVAL_TRIES_LIMIT;
			cfg_q.clear_tries_limit <= RST_CLEAR_TRIES_LIMIT;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_RESET_STATUS_MASK: cfg_q.reset_status_mask <= pwdata[WORD_W-1:0];
				REG_INTERVAL_SAMPLES: cfg_q.interval_samples <= pwdata[WORD_W-1:0];
				REG_INTERVAL_TRIES_LIMIT: cfg_q.interval_tries_limit <= pwdata[3:0];
				REG_CLEAR_TRIES_LIMIT: cfg_q.clear_tries_limit <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_RESET_STATUS_MASK: prdata = {8'd0, cfg_q.reset_status_mask};
			REG_INTERVAL_SAMPLES: prdata = {8'd0, cfg_q.interval_samples};
			REG_INTERVAL_TRIES_LIMIT: prdata = {28'd0, cfg_q.interval_tries_limit};
			REG_CLEAR_TRIES_LIMIT: prdata = {28'd0, cfg_q.clear_tries_limit};
			default: prdata = 32'd0;
		endcase
	end

endmodule

/* design/mphc_classify.sv */
// ----------------------------------------------------------------------------
// mphc_classify
// Sweep state and poll classification for one registered item.
// ----------------------------------------------------------------------------
module mphc_classify (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  mphc_pkg::mphc_item_t item,
	input  mphc_pkg::mphc_cfg_t cfg,
	output logic has_result,
	output mphc_pkg::mphc_result_t result
);
	import mphc_pkg::*;

	logic all_zero_q, all_ones_q;
	logic [WORD_W-1:0] firmware_q, status_q, first_cycle_q;
	logic [3:0] interval_tries_q, clear_tries_q;

	logic is_word, slot_first, slot_last, slot_track;
	logic zero_n, ones_n;
	logic fw_bad, stale, reboot;
	logic int_inc, clr_inc, tries_clr;

	always_comb begin
		is_word = (item.mode == MODE_WORD);
		slot_first = is_word && (item.word_index == 4'd0);
		slot_last = is_word && (item.word_index == LAST_SLOT);
		slot_track = is_word && (item.word_index != 4'd0) && (item.word_index <= LAST_SLOT);
		// flags including the current word
		zero_n = all_zero_q & (item.word_value == '0);
		ones_n = all_ones_q & (item.word_value == WORD_ONES);
		fw_bad = (firmware_q == '0) || (firmware_q == WORD_ONES);
		stale = (item.word_value == first_cycle_q);
		reboot = |(status_q & cfg.reset_status_mask);

		has_result = !is_word || slot_last;
		result = '0;
		int_inc = 1'b0;
		clr_inc = 1'b0;
		tries_clr = 1'b0;

		if (!is_word) begin
			result.bus_busy = (item.bus_error == BERR_BUSY);
			result.error_code = {2'd0, item.bus_error} + 4'd1;
		end else if (zero_n) begin
			result.error_code = ERR_ALL_ZERO;
		end else if (ones_n) begin
			result.error_code = ERR_ALL_ONES;
		end else if (fw_bad) begin
			result.error_code = ERR_NO_LINK;
		end else if (stale) begin
			result.link_good = 1'b1;
			result.error_code = ERR_STALE;
		end else begin
			result.poll_ok = 1'b1;
			result.link_good = 1'b1;
			result.meter_alive = 1'b1;
			result.error_code = ERR_NONE;
			priority if (!reboot) begin
				tries_clr = slot_last;
			end else if (interval_tries_q < cfg.interval_tries_limit) begin
				int_inc = slot_last;
				result.fix_action = FIX_INTERVAL;
				result.fix_data = cfg.interval_samples;
			end else if (clear_tries_q < cfg.clear_tries_limit) begin
				clr_inc = slot_last;
				result.fix_action = FIX_CLEAR;
				result.fix_data = cfg.reset_status_mask;
			end else begin
				// tries spent: no write, counters hold
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_zero_q <= 1'b1;
			all_ones_q <= 1'b1;
			firmware_q <= '0;
			status_q <= '0;
			first_cycle_q <= '0;
			interval_tries_q <= '0;
			clear_tries_q <= '0;
		end else if (fire) begin
			if (!is_word || slot_first || slot_last) begin
				all_zero_q <= 1'b1;
				all_ones_q <= 1'b1;
			end else if (slot_track) begin
				all_zero_q <= zero_n;
				all_ones_q <= ones_n;
			end
			if (slot_first) first_cycle_q <= item.word_value;
			if (is_word && item.word_index == 4'd1) firmware_q <= item.word_value;
			if (is_word && item.word_index == 4'd2) status_q <= item.word_value;
			if (tries_clr) begin
				interval_tries_q <= '0;
				clear_tries_q <= '0;
			end
			if (int_inc) interval_tries_q <= interval_tries_q + 4'd1;
			if (clr_inc) clear_tries_q <= clear_tries_q + 4'd1;
		end
	end

endmodule

/* design/meter_poll_health_checker.sv */
// ----------------------------------------------------------------------------
// meter_poll_health_checker
// Checks one meter poll sweep word by word and reports the poll outcome.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tuser: mode; s_tdata: bus_error,
//          |     |                    | word_index, word_value
//  m_*     | out | m_tvalid/m_tready  | m_tdata: poll outcome
//  apb     | in  | psel/penable       | 4 config registers at 0x0..0xC
//
// An item is registered in stage 1, classified there against the sweep
// state and the result lands in the stage 2 output register, which
// drives m_tvalid; one item per cycle sustained while the output is
// not stalled.
// Sweep state updates as an item leaves stage 1, so the next item in
// stage 1 always sees it.
// A stalled output holds; stage 1 still takes items that make no result
// and s_tready drops only while stage 1 holds a result with nowhere to go.
// arst_n clears valids, stored words and try counters, sets the sweep
// flags and loads the register defaults.
//
module meter_poll_health_checker (
	input  logic clk,
	input  logic arst_n,
	// item in
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata,  // [1:0] bus_error, [5:2] word_index, [29:6] word_value
	input  logic s_tuser,         // [0] mode
	// result out
	output logic m_tvalid,
	input  logic m_tready,
	output logic [39:0] m_tdata,  // [0] poll_ok, [1] link_good, [2] meter_alive,
	                              // [3] bus_busy, [7:4] error_code,
	                              // [9:8] fix_action, [33:10] fix_data
	// config
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import mphc_pkg::*;

	mphc_cfg_t cfg;
	mphc_item_t item_s1;
	logic valid_s1;
	logic adv_s1;
	logic has_result;
	mphc_result_t result;
	mphc_result_t result_s2;
	logic valid_s2;

	mphc_cfg_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	// stage 1 leaves when it makes no result or the output register frees up
	assign adv_s1 = valid_s1 && (!has_result || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.mode <= s_tuser;
			item_s1.bus_error <= s_tdata[1:0];
			item_s1.word_index <= s_tdata[5:2];
			item_s1.word_value <= s_tdata[29:6];
		end
	end

	mphc_classify u_cls (
		.clk(clk),
		.arst_n(arst_n),
		.fire(adv_s1),
		.item(item_s1),
		.cfg(cfg),
		.has_result(has_result),
		.result(result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && has_result) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_result) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {6'd0, result_s2};

endmodule

/* design/mphc_checker.sv */
// ----------------------------------------------------------------------------
// mphc_checker
// Port-level checks on the poll results, bound to the top level.
// ----------------------------------------------------------------------------
module mphc_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [39:0] m_tdata
);
	import mphc_pkg::*;

	logic poll_ok, link_good, meter_alive, bus_busy;
	logic [3:0] error_code;
	logic [1:0] fix_action;
	logic [WORD_W-1:0] fix_data;

	assign poll_ok = m_tdata[0];
	assign link_good = m_tdata[1];
	assign meter_alive = m_tdata[2];
	assign bus_busy = m_tdata[3];
	assign error_code = m_tdata[7:4];
	assign fix_action = m_tdata[9:8];
	assign fix_data = m_tdata[33:10];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an ok poll passed everything
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && poll_ok |-> error_code == ERR_NONE && link_good && meter_alive)
		else $error("ok poll with failed check");

	// failed polls never write
	a_nofix: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !poll_ok |-> fix_action == FIX_NONE && fix_data == '0)
		else $error("housekeeping write on failed poll");

	// busy flag only with busy code
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && bus_busy |-> error_code == ERR_BUSY && !link_good)
		else $error("busy flag with wrong code");

	// no action means no data
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && fix_action == FIX_NONE |-> fix_data == '0)
		else $error("write data without action");

endmodule

bind meter_poll_health_checker mphc_checker u_mphc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
